/* sv/ise_pkg.sv */
// Shared types and constants for the insertion sort engine.
package ise_pkg;

  localparam int ISE_CAPACITY   = 8;
  localparam int ISE_VALUE_BITS = 32;

  typedef enum logic {
    ISE_IDLE,
    ISE_EMIT
  } ise_state_t;

  typedef struct packed {
    logic insert;
    logic drop;
    logic shift;
  } ise_cmd_t;

  typedef struct packed {
    logic full;
    logic last_one;
  } ise_sts_t;

endpackage

/* sv/ise_ctrl.sv */
// Controller state machine: accepts items and sequences the sorted run.
module ise_ctrl
  import ise_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     in_last,
  input  ise_sts_t sts,
  output ise_cmd_t cmd,
  output logic     busy,
  output logic     out_valid
);

  ise_state_t state_r;
  ise_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ISE_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ISE_IDLE: begin
        if (start && in_last) begin
          state_nxt = ISE_EMIT;
        end
      end
      ISE_EMIT: begin
        if (sts.last_one) begin
          state_nxt = ISE_IDLE;
        end
      end
      default: begin
        state_nxt = ISE_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    busy      = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ISE_IDLE: begin
        cmd.insert = start && !sts.full;
        cmd.drop   = start && sts.full;
      end
      ISE_EMIT: begin
        cmd.shift = 1'b1;
        busy      = 1'b1;
        out_valid = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* sv/ise_datapath.sv */
// Datapath: row of compare-and-shift cells, fill count and drop flag.
module ise_datapath
  import ise_pkg::*;
#(
  parameter int CAPACITY   = ISE_CAPACITY,
  parameter int VALUE_BITS = ISE_VALUE_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ise_cmd_t                     cmd,
  input  logic signed [VALUE_BITS-1:0] in_value,
  output ise_sts_t                     sts,
  output logic signed [VALUE_BITS-1:0] out_sorted_value,
  output logic                         out_final_res,
  output logic                         out_overflowed
);

  localparam int CNT_BITS = $clog2(CAPACITY + 1);

  logic signed [VALUE_BITS-1:0] store_r   [CAPACITY];
  logic signed [VALUE_BITS-1:0] store_nxt [CAPACITY];
  logic        [CAPACITY-1:0]   gt;
  logic        [CNT_BITS-1:0]   count_r;
  logic        [CNT_BITS-1:0]   count_nxt;
  logic                         drop_r;
  logic                         drop_nxt;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic prev_gt;
    logic shift_in;

    assign gt[i] = (CNT_BITS'(i) < count_r) && (store_r[i] > in_value);

    if (i == 0) begin : g_first
      assign prev_gt = 1'b0;
    end else begin : g_rest
      assign prev_gt = gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_top
      assign shift_in = 1'b0;
    end else begin : g_below
      assign shift_in = 1'b1;
    end

    always_comb begin
      store_nxt[i] = store_r[i];
      if (cmd.shift) begin
        if (shift_in) begin
          store_nxt[i] = store_r[(i == CAPACITY - 1) ? i : i + 1];
        end
      end else if (cmd.insert) begin
        if (prev_gt) begin
          store_nxt[i] = store_r[(i == 0) ? 0 : i - 1];
        end else if (gt[i] || (count_r == CNT_BITS'(i))) begin
          store_nxt[i] = in_value;
        end
      end
    end

    always_ff @(posedge clk) begin
      store_r[i] <= store_nxt[i];
    end
  end

  always_comb begin
    count_nxt = count_r;
    drop_nxt  = drop_r;
    if (cmd.insert) begin
      count_nxt = count_r + CNT_BITS'(1);
    end
    if (cmd.drop) begin
      drop_nxt = 1'b1;
    end
    if (cmd.shift) begin
      count_nxt = count_r - CNT_BITS'(1);
      if (sts.last_one) begin
        drop_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      drop_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      drop_r  <= drop_nxt;
    end
  end

  assign sts.full         = (count_r == CNT_BITS'(CAPACITY));
  assign sts.last_one     = (count_r == CNT_BITS'(1));
  assign out_sorted_value = store_r[0];
  assign out_final_res    = sts.last_one;
  assign out_overflowed   = drop_r;

endmodule

/* sv/insertion_sort_engine.sv */
// Top level: insertion sort engine, controller plus cell-row datapath.
// Insert: a new item may be given on every clock while idle; busy stays low while a set is being loaded.
// On an item with in_last high the run starts the next cycle: one result per
// cycle, N results for N held values, busy high until the final one is shown.
// The next set may start right after the run of the previous one ends.
// rst_n is synchronous: clears the count, the drop flag and the state machine.
module insertion_sort_engine
  import ise_pkg::*;
#(
  parameter int CAPACITY   = ISE_CAPACITY,
  parameter int VALUE_BITS = ISE_VALUE_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [VALUE_BITS-1:0] in_value,
  input  logic                         in_last,
  output logic                         out_valid,
  output logic signed [VALUE_BITS-1:0] out_sorted_value,
  output logic                         out_final_res,
  output logic                         out_overflowed
);

  ise_cmd_t cmd;
  ise_sts_t sts;

  ise_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_last   (in_last),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  ise_datapath #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_value         (in_value),
    .sts              (sts),
    .out_sorted_value (out_sorted_value),
    .out_final_res    (out_final_res),
    .out_overflowed   (out_overflowed)
  );

endmodule

/* sv/ise_checker.sv */
// Port-level checker for the insertion sort engine, with its bind.
module ise_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_last,
  input logic out_valid,
  input logic out_final_res,
  input logic out_overflowed
);

  a_last_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_last |=> out_valid)
    else $error("run did not start after last item");

  a_plain_item_silent: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_last |=> !out_valid)
    else $error("result emitted without a last item");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_final_res |=> out_valid)
    else $error("run broke off before its final item");

  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_final_res |=> !out_valid)
    else $error("result emitted after the final item");

  a_overflow_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_final_res |=> out_overflowed == $past(out_overflowed))
    else $error("overflow flag changed within a run");

endmodule

bind insertion_sort_engine ise_checker u_ise_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_last        (in_last),
  .out_valid      (out_valid),
  .out_final_res  (out_final_res),
  .out_overflowed (out_overflowed)
);
